// File: hw/rtl/cda_pkg.sv
// Shared constants, types and calendar functions for the date day adder.
`default_nettype none

package cda_pkg;

    localparam int YEAR_BITS  = 14;
    localparam int COUNT_BITS = 16;
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int LEN_BITS   = 5;
    // year mod 400 fits in 9 bits
    localparam int YMOD_BITS  = 9;

    // restoring reduction of a loaded year by 400 << k, k high to low
    localparam int RED_STEPS = (YEAR_BITS > 9) ? YEAR_BITS - 8 : 1;
    localparam int DVS_BITS  = RED_STEPS + 8;
    localparam int CMP_BITS  = (DVS_BITS > YEAR_BITS) ? DVS_BITS : YEAR_BITS;
    localparam logic [DVS_BITS-1:0] DVS_INIT = DVS_BITS'(400 * (2 ** (RED_STEPS - 1)));
    localparam logic [DVS_BITS-1:0] DVS_LAST = DVS_BITS'(400);

    localparam logic [YEAR_BITS-1:0] RESET_YEAR = YEAR_BITS'(2000 % (2 ** YEAR_BITS));
    localparam logic [YMOD_BITS-1:0] RESET_YMOD =
        YMOD_BITS'((2000 % (2 ** YEAR_BITS)) % 400);

    localparam logic [YMOD_BITS-1:0] YMOD_LAST   = YMOD_BITS'(399);
    localparam logic [YMOD_BITS-1:0] YMOD_CENT1  = YMOD_BITS'(100);
    localparam logic [YMOD_BITS-1:0] YMOD_CENT2  = YMOD_BITS'(200);
    localparam logic [YMOD_BITS-1:0] YMOD_CENT3  = YMOD_BITS'(300);

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);
    localparam logic [DAY_BITS-1:0]   DAY_FIRST = DAY_BITS'(1);

    localparam logic [LEN_BITS-1:0] FEB_LEAP = LEN_BITS'(29);
    localparam logic [LEN_BITS-1:0] FEB_NORM = LEN_BITS'(28);

    localparam logic [LEN_BITS-1:0] MONTH_LEN [12] = '{
        LEN_BITS'(31), LEN_BITS'(28), LEN_BITS'(31), LEN_BITS'(30),
        LEN_BITS'(31), LEN_BITS'(30), LEN_BITS'(31), LEN_BITS'(31),
        LEN_BITS'(30), LEN_BITS'(31), LEN_BITS'(30), LEN_BITS'(31)
    };

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ADD  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                  cmd;
        logic [YEAR_BITS-1:0]  new_year;
        logic [MONTH_BITS-1:0] new_month;
        logic [DAY_BITS-1:0]   new_day;
        logic [COUNT_BITS-1:0] day_count;
    } t_in_item;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic red;
        logic chk;
        logic add;
        logic push;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic red_last;
        logic add_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic is_leap(input logic [YMOD_BITS-1:0] ymod);
        return ((ymod[1:0] == 2'b00) && (ymod != YMOD_CENT1) && (ymod != YMOD_CENT2)
                && (ymod != YMOD_CENT3)) || (ymod == '0);
    endfunction

    // zero for a month code outside 1..12
    function automatic logic [LEN_BITS-1:0] month_len(input logic leap,
                                                      input logic [MONTH_BITS-1:0] month);
        logic [MONTH_BITS-1:0] idx;
        idx = month - MONTH_JAN;
        if (month == MONTH_FEB) begin
            return leap ? FEB_LEAP : FEB_NORM;
        end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            return MONTH_LEN[idx];
        end else begin
            return '0;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cda_in_if.sv
// Command channel: valid/ready handshake with the command beat payload.
`default_nettype none

interface cda_in_if import cda_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [YEAR_BITS-1:0]  new_year;
    logic [MONTH_BITS-1:0] new_month;
    logic [DAY_BITS-1:0]   new_day;
    logic [COUNT_BITS-1:0] day_count;

    modport source (output valid, cmd, new_year, new_month, new_day, day_count,
                    input ready);
    modport sink   (input valid, cmd, new_year, new_month, new_day, day_count,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cda_res_if.sv
// Result channel: valid/ready handshake with the resulting date beat.
`default_nettype none

interface cda_res_if import cda_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [YEAR_BITS-1:0]  cur_year;
    logic [MONTH_BITS-1:0] cur_month;
    logic [DAY_BITS-1:0]   cur_day;
    logic                  bad_date;

    modport source (output valid, cur_year, cur_month, cur_day, bad_date, input ready);
    modport sink   (input valid, cur_year, cur_month, cur_day, bad_date, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/calendar_date_day_adder.sv
// Top level of the calendar date day adder: controller, datapath and checks.
//
//  channel  dir  modport  beat contents
//  i_in     in   sink     cmd, new_year, new_month, new_day, day_count
//  o_res    out  source   cur_year, cur_month, cur_day, bad_date
//
// Load: capture, reduction of the year mod 400 one bit a cycle, a load check,
// then the hand-off. Add: capture, one month per cycle through a single month
// stepper, the final in-month add, then the hand-off.
// Synchronous reset sets the date to 2000-01-01; no clearing pass.
// A result sits in the output register until taken; the next command is accepted
// meanwhile, and only its own hand-off waits on the register.
`default_nettype none

module calendar_date_day_adder import cda_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cda_in_if.sink    i_in,
    cda_res_if.source o_res
);

    t_dp_cmd  dp_cmd;
    t_dp_sts  dp_sts;
    t_in_item in_item;
    logic     in_ready;

    assign in_item.cmd       = i_in.cmd;
    assign in_item.new_year  = i_in.new_year;
    assign in_item.new_month = i_in.new_month;
    assign in_item.new_day   = i_in.new_day;
    assign in_item.day_count = i_in.day_count;
    assign i_in.ready        = in_ready;

    cda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    cda_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_item  (in_item),
        .o_sts   (dp_sts),
        .o_res   (o_res)
    );

    // an accepted beat leaves the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("command accepted while still idle next cycle");

    // no datapath work while waiting for a command
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !(dp_cmd.red || dp_cmd.chk || dp_cmd.add || dp_cmd.push))
        else $error("datapath step issued while idle");

    // every presented date has a month in 1..12 and a nonzero day
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.cur_month >= MONTH_JAN) && (o_res.cur_month <= MONTH_DEC)
                        && (o_res.cur_day != '0))
        else $error("result date out of range");

endmodule

`default_nettype wire

// File: hw/rtl/cda_ctrl.sv
// Controller state machine sequencing year reduction, load checks, month steps and result hand-off.
`default_nettype none

module cda_ctrl import cda_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_cmd,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_CHK  = 5'b00100,
        S_ADD  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = (i_in_cmd == CMD_ADD) ? S_ADD : S_RED;
                end
            end
            S_RED: begin
                o_cmd.red = 1'b1;
                if (i_sts.red_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_PUSH;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (i_sts.add_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/cda_dp.sv
// Datapath: date registers, year-mod-400 tracking, month stepper and result register.
`default_nettype none

module cda_dp import cda_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_item i_item,
    output t_dp_sts       o_sts,
    cda_res_if.source     o_res
);

    // current date; r_ymod follows r_year mod 400
    logic [YEAR_BITS-1:0]  r_year;
    logic [MONTH_BITS-1:0] r_month;
    logic [DAY_BITS-1:0]   r_day;
    logic [YMOD_BITS-1:0]  r_ymod;

    logic [COUNT_BITS-1:0] r_left;
    logic [YEAR_BITS-1:0]  r_ny;
    logic [MONTH_BITS-1:0] r_nm;
    logic [DAY_BITS-1:0]   r_nd;
    logic [CMP_BITS-1:0]   r_lmod;
    logic [DVS_BITS-1:0]   r_dvs;
    logic                  r_bad;

    logic                  r_out_valid;
    logic [YEAR_BITS-1:0]  r_out_year;
    logic [MONTH_BITS-1:0] r_out_month;
    logic [DAY_BITS-1:0]   r_out_day;
    logic                  r_out_bad;

    logic [LEN_BITS-1:0]   cur_len;
    logic [COUNT_BITS:0]   day_sum;
    logic                  add_fits;
    logic [LEN_BITS:0]     step_days;
    logic [CMP_BITS-1:0]   dvs_ext;
    logic                  red_ge;
    logic [YMOD_BITS-1:0]  ld_ymod;
    logic [LEN_BITS-1:0]   ld_len;
    logic                  ld_ok;
    logic                  year_top;

    assign cur_len   = month_len(is_leap(r_ymod), r_month);
    assign day_sum   = (COUNT_BITS+1)'(r_day) + (COUNT_BITS+1)'(r_left);
    assign add_fits  = day_sum <= (COUNT_BITS+1)'(cur_len);
    // days left in this month including today, i.e. the jump to the 1st of the next
    assign step_days = (LEN_BITS+1)'(cur_len) - (LEN_BITS+1)'(r_day) + (LEN_BITS+1)'(1);
    assign year_top  = (r_year == '1);

    assign dvs_ext = CMP_BITS'(r_dvs);
    assign red_ge  = r_lmod >= dvs_ext;

    assign ld_ymod = r_lmod[YMOD_BITS-1:0];
    assign ld_len  = month_len(is_leap(ld_ymod), r_nm);
    assign ld_ok   = (r_nm >= MONTH_JAN) && (r_nm <= MONTH_DEC) && (r_nd != '0)
                     && (r_nd <= DAY_BITS'(ld_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= RESET_YEAR;
            r_month <= MONTH_JAN;
            r_day   <= DAY_FIRST;
            r_ymod  <= RESET_YMOD;
        end else if (i_cmd.chk) begin
            if (ld_ok) begin
                r_year  <= r_ny;
                r_month <= r_nm;
                r_day   <= r_nd;
                r_ymod  <= ld_ymod;
            end
        end else if (i_cmd.add) begin
            if (add_fits) begin
                r_day <= DAY_BITS'(day_sum);
            end else begin
                r_day <= DAY_FIRST;
                if (r_month == MONTH_DEC) begin
                    r_month <= MONTH_JAN;
                    r_year  <= r_year + YEAR_BITS'(1);
                    // wrap of the year register lands on year 0, a multiple of 400
                    if (year_top || r_ymod == YMOD_LAST) begin
                        r_ymod <= '0;
                    end else begin
                        r_ymod <= r_ymod + YMOD_BITS'(1);
                    end
                end else begin
                    r_month <= r_month + MONTH_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_left <= i_item.day_count;
            r_ny   <= i_item.new_year;
            r_nm   <= i_item.new_month;
            r_nd   <= i_item.new_day;
            r_lmod <= CMP_BITS'(i_item.new_year);
            r_dvs  <= DVS_INIT;
            r_bad  <= 1'b0;
        end else begin
            if (i_cmd.add && !add_fits) begin
                r_left <= r_left - COUNT_BITS'(step_days);
            end
            if (i_cmd.red) begin
                if (red_ge) begin
                    r_lmod <= r_lmod - dvs_ext;
                end
                r_dvs <= r_dvs >> 1;
            end
            if (i_cmd.chk) begin
                r_bad <= !ld_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_year  <= r_year;
            r_out_month <= r_month;
            r_out_day   <= r_day;
            r_out_bad   <= r_bad;
        end
    end

    assign o_sts.red_last = (r_dvs == DVS_LAST);
    assign o_sts.add_last = add_fits;
    assign o_sts.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.cur_year  = r_out_year;
    assign o_res.cur_month = r_out_month;
    assign o_res.cur_day   = r_out_day;
    assign o_res.bad_date  = r_out_bad;

endmodule

`default_nettype wire
